// File: design/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W      = 9;
  localparam int PCT_W      = 7;
  localparam int POS_W      = 6;
  localparam int STEP_W     = 4;
  localparam int PROD_W     = 14;
  localparam int NUM_W      = 20;

  localparam int PCT_FULL   = 100;
  localparam int SECTOR_DEG = 60;
  localparam int SECTORS    = 6;
  localparam int HUE_STEPS  = 8;

  // round(num * 2^F / 600000) = floor((num * 2^(F-5) + 9375) / 18750)
  localparam int DIV_SHIFT  = 5;
  localparam int DIV_BASE   = 18750;
  localparam int DIV_HALF   = DIV_BASE / 2;
  localparam int RCP_SHIFT  = 32;
  localparam int RCP_W      = 18;
  localparam longint unsigned RCP = (64'd1 << RCP_SHIFT) / DIV_BASE;

  typedef enum logic [2:0] {
    SEC_000 = 3'd0,
    SEC_060 = 3'd1,
    SEC_120 = 3'd2,
    SEC_180 = 3'd3,
    SEC_240 = 3'd4,
    SEC_300 = 3'd5
  } sector_t;

endpackage

// File: design/hsv_to_rgb_converter_unit.sv
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Converts one HSV color per request into RGB channel fractions.
// ---------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns the results in order.
// Six register stages: sector split, percent products, ramp products, channel
// select, reciprocal multiply, remainder correction. Each stage has its own
// valid bit and ready term, so bubbles are squeezed out while the output is
// stalled. Saturation and value above 100 are clamped to 100; hue above 359
// wraps. Channels are unsigned fractions with OUT_FRAC_BITS fraction bits,
// rounded to nearest.
module hsv_to_rgb_converter_unit #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [8:0] hue_deg, [15:9] sat_pct, [22:16] val_pct, [23] zero
  input  logic [23:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // red_frac, green_frac, blue_frac from bit 0, OUT_FRAC_BITS+1 bits each
  output logic [((3*(OUT_FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CH_W  = OUT_FRAC_BITS + 1;
  localparam int OUT_W = 3 * CH_W;
  localparam int TD_W  = ((OUT_W + 7) / 8) * 8;
  localparam int Y_W   = hsv2rgb_pkg::NUM_W + OUT_FRAC_BITS - hsv2rgb_pkg::DIV_SHIFT + 1;
  localparam int P_W   = Y_W + hsv2rgb_pkg::RCP_W;
  localparam int NSTG  = 6;

  localparam logic [hsv2rgb_pkg::RCP_W-1:0] RCP_K = hsv2rgb_pkg::RCP_W'(hsv2rgb_pkg::RCP);

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  // stage 1 comb
  logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
  logic [hsv2rgb_pkg::PCT_W-1:0]  sat_in;
  logic [hsv2rgb_pkg::PCT_W-1:0]  val_in;
  logic [hsv2rgb_pkg::PCT_W-1:0]  sat_cl;
  logic [hsv2rgb_pkg::PCT_W-1:0]  val_cl;
  logic [hsv2rgb_pkg::STEP_W-1:0] step;
  logic [hsv2rgb_pkg::STEP_W-1:0] sec_idx;
  logic [hsv2rgb_pkg::HUE_W-1:0]  pos_full;

  // stage registers
  logic [hsv2rgb_pkg::PCT_W-1:0]  s1_sat;
  logic [hsv2rgb_pkg::PCT_W-1:0]  s1_val;
  logic [hsv2rgb_pkg::PCT_W-1:0]  s1_sat_c;
  hsv2rgb_pkg::sector_t           s1_sec;
  logic [hsv2rgb_pkg::POS_W-1:0]  s1_pos;

  logic [hsv2rgb_pkg::NUM_W-1:0]  s2_nv;
  logic [hsv2rgb_pkg::PROD_W-1:0] s2_cv;
  logic [hsv2rgb_pkg::PROD_W-1:0] s2_sv;
  hsv2rgb_pkg::sector_t           s2_sec;
  logic [hsv2rgb_pkg::POS_W-1:0]  s2_pos;

  logic [hsv2rgb_pkg::NUM_W-1:0]  s3_nv;
  logic [hsv2rgb_pkg::NUM_W-1:0]  s3_nmin;
  logic [hsv2rgb_pkg::NUM_W-1:0]  s3_na;
  hsv2rgb_pkg::sector_t           s3_sec;

  logic [hsv2rgb_pkg::NUM_W-1:0]  ninc;
  logic [hsv2rgb_pkg::NUM_W-1:0]  ndec;
  logic [2:0][hsv2rgb_pkg::NUM_W-1:0] num_sel;
  logic [2:0][hsv2rgb_pkg::NUM_W-1:0] s4_num;

  logic [2:0][Y_W-1:0]  y_val;
  logic [2:0][P_W-1:0]  y_prod;
  logic [2:0][Y_W-1:0]  s5_y;
  logic [2:0][CH_W-1:0] s5_qe;

  logic [2:0][Y_W-1:0]  rem;
  logic [2:0][CH_W-1:0] q_fix;
  logic [2:0][CH_W-1:0] s6_ch;

  // per-stage ready chain
  always_comb begin
    en[NSTG] = m_axis_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NSTG-1];
  assign m_axis_tdata  = TD_W'({s6_ch[2], s6_ch[1], s6_ch[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: clamp, sector and position
  always_comb begin
    hue    = s_axis_tdata[8:0];
    sat_in = s_axis_tdata[15:9];
    val_in = s_axis_tdata[22:16];
    sat_cl = (sat_in > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_FULL)) ?
             hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_FULL) : sat_in;
    val_cl = (val_in > hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_FULL)) ?
             hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_FULL) : val_in;
    step = '0;
    for (int k = 1; k <= hsv2rgb_pkg::HUE_STEPS; k++) begin
      if (hue >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SECTOR_DEG)) begin
        step = hsv2rgb_pkg::STEP_W'(k);
      end
    end
    pos_full = hue - hsv2rgb_pkg::HUE_W'(step * hsv2rgb_pkg::SECTOR_DEG);
    sec_idx  = (step >= hsv2rgb_pkg::STEP_W'(hsv2rgb_pkg::SECTORS)) ?
               step - hsv2rgb_pkg::STEP_W'(hsv2rgb_pkg::SECTORS) : step;
  end

  // stage 4: ramp ends and channel routing
  always_comb begin
    ninc = s3_nmin + s3_na;
    ndec = s3_nv - s3_na;
    case (s3_sec)
      hsv2rgb_pkg::SEC_000: begin
        num_sel[0] = s3_nv;   num_sel[1] = ninc;    num_sel[2] = s3_nmin;
      end
      hsv2rgb_pkg::SEC_060: begin
        num_sel[0] = ndec;    num_sel[1] = s3_nv;   num_sel[2] = s3_nmin;
      end
      hsv2rgb_pkg::SEC_120: begin
        num_sel[0] = s3_nmin; num_sel[1] = s3_nv;   num_sel[2] = ninc;
      end
      hsv2rgb_pkg::SEC_180: begin
        num_sel[0] = s3_nmin; num_sel[1] = ndec;    num_sel[2] = s3_nv;
      end
      hsv2rgb_pkg::SEC_240: begin
        num_sel[0] = ninc;    num_sel[1] = s3_nmin; num_sel[2] = s3_nv;
      end
      default: begin
        num_sel[0] = s3_nv;   num_sel[1] = s3_nmin; num_sel[2] = ndec;
      end
    endcase
  end

  // stages 5 and 6: divide by 18750 via reciprocal, then one correction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y_val[c]  = (Y_W'(s4_num[c]) << (OUT_FRAC_BITS - hsv2rgb_pkg::DIV_SHIFT)) +
                  Y_W'(hsv2rgb_pkg::DIV_HALF);
      y_prod[c] = P_W'(y_val[c]) * P_W'(RCP_K);
      rem[c]    = s5_y[c] - Y_W'(s5_qe[c] * hsv2rgb_pkg::DIV_BASE);
      q_fix[c]  = s5_qe[c] + CH_W'(rem[c] >= Y_W'(hsv2rgb_pkg::DIV_BASE));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sat   <= sat_cl;
      s1_val   <= val_cl;
      s1_sat_c <= hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_FULL) - sat_cl;
      s1_sec   <= hsv2rgb_pkg::sector_t'(sec_idx[2:0]);
      s1_pos   <= pos_full[hsv2rgb_pkg::POS_W-1:0];
    end
    if (en[1]) begin
      s2_nv  <= hsv2rgb_pkg::NUM_W'(s1_val) *
                hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::PCT_FULL * hsv2rgb_pkg::SECTOR_DEG);
      s2_cv  <= hsv2rgb_pkg::PROD_W'(s1_sat_c) * hsv2rgb_pkg::PROD_W'(s1_val);
      s2_sv  <= hsv2rgb_pkg::PROD_W'(s1_sat) * hsv2rgb_pkg::PROD_W'(s1_val);
      s2_sec <= s1_sec;
      s2_pos <= s1_pos;
    end
    if (en[2]) begin
      s3_nv   <= s2_nv;
      s3_nmin <= hsv2rgb_pkg::NUM_W'(s2_cv) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SECTOR_DEG);
      s3_na   <= hsv2rgb_pkg::NUM_W'(s2_sv) * hsv2rgb_pkg::NUM_W'(s2_pos);
      s3_sec  <= s2_sec;
    end
    if (en[3]) begin
      s4_num <= num_sel;
    end
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        s5_y[c]  <= y_val[c];
        s5_qe[c] <= y_prod[c][hsv2rgb_pkg::RCP_SHIFT +: CH_W];
      end
    end
    if (en[5]) begin
      s6_ch <= q_fix;
    end
  end

endmodule
